// ----- sv/big5u_pkg.sv -----
`default_nettype none
package big5u_pkg;

	// One table word: Big5 code over Unicode value
	typedef struct packed {
		logic [15:0] code;
		logic [20:0] uni;
	} map_word_t;

	// Request and response between the top level and the table search
	typedef struct packed {
		logic        start;
		logic [15:0] code;
	} srch_req_t;

	typedef struct packed {
		logic        done;
		logic [20:0] uni;
	} srch_rsp_t;

	// UTF-8 form of one scalar: byte count and bytes, first byte at [0]
	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] b;
	} utf8_t;

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD_LO    = 8'h81;
	localparam logic [7:0] LEAD_HI    = 8'hFE;
	localparam logic [7:0] TRAIL_A_LO = 8'h40;
	localparam logic [7:0] TRAIL_A_HI = 8'h7E;
	localparam logic [7:0] TRAIL_B_LO = 8'hA1;
	localparam logic [7:0] TRAIL_B_HI = 8'hFE;

	localparam logic REG_TABLE_ENTRIES = 1'b0;
	localparam logic REG_OUT_CAPACITY  = 1'b1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	function automatic logic pair_valid(input logic [7:0] lead, input logic [7:0] trail);
		logic l;
		logic t;
		l = (lead >= LEAD_LO) && (lead <= LEAD_HI);
		t = ((trail >= TRAIL_A_LO) && (trail <= TRAIL_A_HI)) ||
		    ((trail >= TRAIL_B_LO) && (trail <= TRAIL_B_HI));
		return l && t;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] u);
		utf8_t e;
		e = '0;
		if (u < 21'h80) begin
			e.len  = 3'd1;
			e.b[0] = u[7:0];
		end else if (u < 21'h800) begin
			e.len  = 3'd2;
			e.b[0] = {3'b110, u[10:6]};
			e.b[1] = {2'b10, u[5:0]};
		end else if (u < 21'h10000) begin
			e.len  = 3'd3;
			e.b[0] = {4'b1110, u[15:12]};
			e.b[1] = {2'b10, u[11:6]};
			e.b[2] = {2'b10, u[5:0]};
		end else begin
			e.len  = 3'd4;
			e.b[0] = {5'b11110, u[20:18]};
			e.b[1] = {2'b10, u[17:12]};
			e.b[2] = {2'b10, u[11:6]};
			e.b[3] = {2'b10, u[5:0]};
		end
		return e;
	endfunction

endpackage
`default_nettype wire

// ----- sv/big5u_ifs.sv -----
`default_nettype none
// Input channel: table loads and source bytes
interface big5u_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [13:0] entry_index;
	logic [15:0] entry_big5;
	logic [20:0] entry_unicode;
	logic [7:0]  src_byte;

	modport source (output valid, op, entry_index, entry_big5, entry_unicode, src_byte,
		input ready);
	modport sink (input valid, op, entry_index, entry_big5, entry_unicode, src_byte,
		output ready);
endinterface

// Output channel: UTF-8 bytes with markers
interface big5u_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] utf8_byte;
	logic       run_last;
	logic       string_end;
	logic       overflow;

	modport source (output valid, utf8_byte, run_last, string_end, overflow, input ready);
	modport sink (input valid, utf8_byte, run_last, string_end, overflow, output ready);
endinterface
`default_nettype wire

// ----- sv/big5u_ram.sv -----
`default_nettype none
// Single-port table memory, registered read
module big5u_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  wire                  clk,
	input  wire                  en,
	input  wire                  we,
	input  wire [AW-1:0]         addr,
	input  big5u_pkg::map_word_t wdata,
	output big5u_pkg::map_word_t rdata
);

	big5u_pkg::map_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/big5u_search.sv -----
`default_nettype none
// Binary search over the loaded table, one memory read per step
module big5u_search #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire [14:0]           table_entries,
	input  big5u_pkg::srch_req_t req,
	output big5u_pkg::srch_rsp_t rsp,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  big5u_pkg::map_word_t rd_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LO   = 2'd1;
	localparam logic [1:0] S_HI   = 2'd2;
	localparam logic [1:0] S_MID  = 2'd3;
	localparam logic [16:0] DEPTH17 = 17'(DEPTH);

	logic [1:0]    state_q;
	logic [15:0]   code_q;
	logic [AW-1:0] lo_q, hi_q, mid_q;
	logic [15:0]   lo_code_q;
	logic [20:0]   lo_uni_q;

	logic [16:0]   ent17, n17;
	logic [AW-1:0] last_idx;
	logic [AW:0]   mid_sum;
	logic [AW-1:0] nlo, nhi;

	// Searched slot count is min(entries, depth)
	assign ent17    = {2'b00, table_entries};
	assign n17      = (ent17 < DEPTH17) ? ent17 : DEPTH17;
	assign last_idx = AW'(n17 - 17'd1);

	// Next bounds after a middle compare
	always_comb begin
		nlo = lo_q;
		nhi = hi_q;
		if (code_q > rd_data.code) begin
			nlo = mid_q;
		end else begin
			nhi = mid_q;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		mid_sum = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = req.start && (req.code > 16'(big5u_pkg::ASCII_MAX)) && (n17 != '0);
				rd_addr = '0;
			end
			S_LO: begin
				rd_en   = 1'b1;
				rd_addr = hi_q;
			end
			S_HI: begin
				mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
				rd_en   = 1'b1;
				rd_addr = mid_sum[AW:1];
			end
			S_MID: begin
				mid_sum = {1'b0, nlo} + {1'b0, nhi};
				rd_en   = 1'b1;
				rd_addr = mid_sum[AW:1];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rsp      <= '0;
			code_q   <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			lo_code_q <= '0;
			lo_uni_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// Done pulse here only for codes that need no table read
					rsp.done <= req.start && !rd_en;
					if (req.start) begin
						code_q <= req.code;
						if (rd_en) begin
							lo_q    <= '0;
							hi_q    <= last_idx;
							state_q <= S_LO;
						end else begin
							rsp.uni  <= {5'd0, req.code};
						end
					end
				end
				S_LO: begin
					lo_code_q <= rd_data.code;
					lo_uni_q  <= rd_data.uni;
					state_q   <= S_HI;
				end
				S_HI: begin
					mid_q <= rd_addr;
					if (code_q < lo_code_q || code_q > rd_data.code) begin
						rsp.done <= 1'b1;
						rsp.uni  <= {5'd0, code_q};
						state_q  <= S_IDLE;
					end else if (code_q == lo_code_q) begin
						rsp.done <= 1'b1;
						rsp.uni  <= lo_uni_q;
						state_q  <= S_IDLE;
					end else if (code_q == rd_data.code) begin
						rsp.done <= 1'b1;
						rsp.uni  <= rd_data.uni;
						state_q  <= S_IDLE;
					end else if ((hi_q - lo_q) > AW'(1)) begin
						state_q <= S_MID;
					end else begin
						rsp.done <= 1'b1;
						rsp.uni  <= {5'd0, code_q};
						state_q  <= S_IDLE;
					end
				end
				S_MID: begin
					lo_q  <= nlo;
					hi_q  <= nhi;
					mid_q <= rd_addr;
					if (code_q == rd_data.code) begin
						rsp.done <= 1'b1;
						rsp.uni  <= rd_data.uni;
						state_q  <= S_IDLE;
					end else if ((nhi - nlo) <= AW'(1)) begin
						rsp.done <= 1'b1;
						rsp.uni  <= {5'd0, code_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					rsp.done <= 1'b0;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/big5_to_utf8_stream_converter_top.sv -----
`default_nettype none
// Channel   Dir  Transaction
// in_ch     in   op=0: table load (slot, code, scalar); op=1: one Big5 source byte
// out_ch    out  one UTF-8 byte, or terminator / overflow marker
// cfg       in   cfg_we, cfg_index, cfg_wdata; one register write per cycle
//
// A table load is written straight into the table memory. A source byte may start a table
// search for each looked-up code (one table memory read per search step), and each output
// byte is sent while out_ch is ready. The table memory has one port.
// Reset clears held byte, counts and flags; the table is undefined until loaded.
// in_ch is stalled while an item is at work; out_ch has a one-entry output register.
module big5_to_utf8_stream_converter_top #(
	parameter int TABLE_DEPTH = 16384
) (
	input  wire                clk,
	input  wire                arst_n,
	big5u_in_if.sink           in_ch,
	big5u_out_if.source        out_ch,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire [15:0]         cfg_wdata
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_NEXT = 2'd3;

	logic [14:0] table_entries_q;
	logic [15:0] out_capacity_q;

	logic [1:0]  state_q;
	logic [7:0]  held_q;
	logic        held_valid_q;
	logic [15:0] bytes_written_q;
	logic        failed_q;
	logic [7:0]  b_q;
	logic        cons_q;
	logic        phase_b_q;

	logic [3:0][7:0] buf_q;
	logic [2:0]  cnt_q;
	logic [2:0]  idx_q;
	logic        em_end_q, em_ovf_q, em_last_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q, out_end_q, out_ovf_q;

	big5u_pkg::srch_req_t req_q;
	big5u_pkg::srch_rsp_t rsp;
	big5u_pkg::map_word_t rd_data, wdata;
	logic          srch_rd_en;
	logic [AW-1:0] srch_addr;

	logic          ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [16:0]   load_idx17;
	logic          load_ok;
	logic          in_acc;
	logic          out_free;

	big5u_pkg::utf8_t enc;
	logic [16:0]   fill_sum;
	logic          no_fit;
	logic          failed_new;
	logic          b_produces;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.utf8_byte  = out_byte_q;
	assign out_ch.run_last   = out_last_q;
	assign out_ch.string_end = out_end_q;
	assign out_ch.overflow   = out_ovf_q;

	// Table write on load, otherwise the search owns the port
	assign load_idx17 = {3'b000, in_ch.entry_index};
	assign load_ok    = in_acc && (in_ch.op == big5u_pkg::OP_LOAD) &&
	                    (load_idx17 < 17'(TABLE_DEPTH));
	assign ram_we     = load_ok;
	assign ram_en     = load_ok || srch_rd_en;
	assign ram_addr   = load_ok ? load_idx17[AW-1:0] : srch_addr;
	assign wdata.code = in_ch.entry_big5;
	assign wdata.uni  = in_ch.entry_unicode;

	big5u_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (rd_data)
	);

	big5u_search #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.table_entries (table_entries_q),
		.req           (req_q),
		.rsp           (rsp),
		.rd_en         (srch_rd_en),
		.rd_addr       (srch_addr),
		.rd_data       (rd_data)
	);

	// Encode the found scalar and check room, terminator slot kept free
	assign enc        = big5u_pkg::utf8_encode(rsp.uni);
	assign fill_sum   = {1'b0, bytes_written_q} + {14'd0, enc.len};
	assign no_fit     = fill_sum >= {1'b0, out_capacity_q};
	assign failed_new = failed_q || no_fit;
	assign b_produces = !cons_q && ((b_q == 8'd0) ||
	                    (!failed_new && (b_q <= big5u_pkg::ASCII_MAX)));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_entries_q <= 15'd16384;
			out_capacity_q  <= 16'd65535;
		end else if (cfg_we) begin
			unique case (cfg_index)
				big5u_pkg::REG_TABLE_ENTRIES: table_entries_q <= cfg_wdata[14:0];
				big5u_pkg::REG_OUT_CAPACITY:  out_capacity_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			held_q          <= '0;
			held_valid_q    <= 1'b0;
			bytes_written_q <= '0;
			failed_q        <= 1'b0;
			b_q             <= '0;
			cons_q          <= 1'b0;
			phase_b_q       <= 1'b0;
			buf_q           <= '0;
			cnt_q           <= '0;
			idx_q           <= '0;
			em_end_q        <= 1'b0;
			em_ovf_q        <= 1'b0;
			em_last_q       <= 1'b0;
			req_q           <= '0;
			out_valid_q     <= 1'b0;
			out_byte_q      <= '0;
			out_last_q      <= 1'b0;
			out_end_q       <= 1'b0;
			out_ovf_q       <= 1'b0;
		end else begin
			// Output register drains unless refilled this cycle
			if (out_valid_q && out_ch.ready && !((state_q == ST_EMIT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_ch.op == big5u_pkg::OP_BYTE)) begin
						b_q       <= in_ch.src_byte;
						phase_b_q <= 1'b0;
						cons_q    <= !failed_q && held_valid_q &&
						             big5u_pkg::pair_valid(held_q, in_ch.src_byte);
						if (!failed_q && held_valid_q) begin
							held_valid_q <= 1'b0;
							req_q.start  <= 1'b1;
							if (big5u_pkg::pair_valid(held_q, in_ch.src_byte)) begin
								req_q.code <= {held_q, in_ch.src_byte};
							end else begin
								req_q.code <= {8'd0, held_q};
							end
							state_q <= ST_LOOK;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_LOOK: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						idx_q     <= '0;
						em_end_q  <= 1'b0;
						em_last_q <= phase_b_q || !b_produces;
						if (no_fit) begin
							failed_q <= 1'b1;
							buf_q    <= '0;
							cnt_q    <= 3'd1;
							em_ovf_q <= 1'b1;
						end else begin
							buf_q           <= enc.b;
							cnt_q           <= enc.len;
							em_ovf_q        <= 1'b0;
							bytes_written_q <= fill_sum[15:0];
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= buf_q[idx_q[1:0]];
						out_end_q   <= em_end_q;
						out_ovf_q   <= em_ovf_q;
						out_last_q  <= em_last_q && (idx_q == cnt_q - 3'd1);
						idx_q       <= idx_q + 3'd1;
						if (idx_q == cnt_q - 3'd1) begin
							state_q <= phase_b_q ? ST_IDLE : ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					phase_b_q <= 1'b1;
					if (cons_q) begin
						state_q <= ST_IDLE;
					end else if (b_q == 8'd0) begin
						// Terminator; clears the string state
						buf_q           <= '0;
						cnt_q           <= 3'd1;
						idx_q           <= '0;
						em_end_q        <= 1'b1;
						em_ovf_q        <= failed_q;
						em_last_q       <= 1'b1;
						held_valid_q    <= 1'b0;
						held_q          <= '0;
						bytes_written_q <= '0;
						failed_q        <= 1'b0;
						state_q         <= ST_EMIT;
					end else if (failed_q) begin
						held_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end else if (b_q > big5u_pkg::ASCII_MAX) begin
						held_q       <= b_q;
						held_valid_q <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						req_q.start <= 1'b1;
						req_q.code  <= {8'd0, b_q};
						state_q     <= ST_LOOK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
